// ----- hw/rtl/tcpcs_pkg.sv -----
package tcpcs_pkg;

    localparam int CSUM_W = 16;

    // kind of byte carried on the input tuser bit
    localparam logic OP_HEADER  = 1'b0;
    localparam logic OP_SEGMENT = 1'b1;

    // header bytes 12..19 carry the source and destination addresses
    localparam logic [4:0] HDR_ADDR_START = 5'd12;
    localparam logic [4:0] HDR_MIN_LEN    = 5'd20;

    localparam logic [15:0] SEG_MIN_LEN       = 16'd20;
    localparam logic [15:0] MAX_SEGMENT_BYTES = 16'hFFFF;
    // low byte of the checksum field, which sits at segment offset 16
    localparam logic [15:0] CSUM_LOW_POS      = 16'd17;

    localparam logic [15:0] PROTO_TCP = 16'd6;

    // ones'-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// ----- hw/rtl/tcp_checksum_ipv4_pseudo_header_top.sv -----
// TCP checksum over the IPv4 pseudo-header, computed from a packet byte stream.
// Input beats (s_axis): one packet byte per beat, tuser = 0 for an IPv4 header
// byte and 1 for a TCP segment byte, tlast on the final byte of the packet.
// Output beats (m_axis): one per packet, sent for the tlast beat; tdata holds
// the inverted folded checksum, tuser holds the too_short and overlong flags
// (checksum is 0 when either flag is set).
// Throughput: one input beat every cycle unless a tlast byte waits on a held
// result; each header or segment byte adds at most one 16-bit ones'-complement
// word into the running sum, done in the cycle after the byte is registered,
// with pseudo-header terms folded into the result register on the last byte.
// Reset clears the running sum, the byte counts and both beat valid flags, so
// the next packet starts clean; state also clears after every result.
// When the receiver stalls, the pending result holds on m_axis; the input side
// keeps taking non-last bytes and stops only once a second tlast beat is
// waiting in the input register behind the held result.
module tcp_checksum_ipv4_pseudo_header_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] operation
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] checksum
    output logic [1:0]  m_axis_tuser    // [0] too_short, [1] overlong
);

    // input beat register
    logic       in_valid_reg;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // packet state
    logic [15:0] sum_reg,  sum_next;
    logic [4:0]  hcnt_reg, hcnt_next;
    logic [15:0] scnt_reg, scnt_next;
    logic [7:0]  held_reg, held_next;
    logic        ovf_reg,  ovf_next;

    // result register
    logic        out_valid_reg;
    logic [15:0] out_csum_reg,  out_csum_next;
    logic        out_short_reg, out_short_next;
    logic        out_long_reg;

    logic        advance;
    logic        process;
    logic        add_en;
    logic [15:0] word;
    logic [15:0] pad;
    logic [17:0] total;
    logic [16:0] fold1;
    logic [15:0] fold2;

    // a last byte can only move on once the result register is free
    assign advance       = !in_last_reg || !out_valid_reg || m_axis_tready;
    assign process       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        add_en    = 1'b0;
        word      = '0;
        hcnt_next = hcnt_reg;
        scnt_next = scnt_reg;
        held_next = held_reg;
        ovf_next  = ovf_reg;
        if (in_op_reg == tcpcs_pkg::OP_HEADER)
        begin
            if (hcnt_reg < tcpcs_pkg::HDR_MIN_LEN)
            begin
                if (hcnt_reg >= tcpcs_pkg::HDR_ADDR_START)
                begin
                    add_en = 1'b1;
                    word   = hcnt_reg[0] ? {8'h00, in_byte_reg} : {in_byte_reg, 8'h00};
                end
                hcnt_next = hcnt_reg + 5'd1;
            end
        end
        else
        begin
            if (scnt_reg >= tcpcs_pkg::MAX_SEGMENT_BYTES)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                if (!scnt_reg[0])
                begin
                    held_next = in_byte_reg;
                end
                else if (scnt_reg != tcpcs_pkg::CSUM_LOW_POS)
                begin
                    add_en = 1'b1;
                    word   = {held_reg, in_byte_reg};
                end
                scnt_next = scnt_reg + 16'd1;
            end
        end
        sum_next = add_en ? tcpcs_pkg::oc_add(sum_reg, word) : sum_reg;

        // closing terms: odd byte padding, protocol and segment length
        pad   = scnt_next[0] ? {held_next, 8'h00} : 16'h0000;
        total = {2'b00, sum_next} + {2'b00, pad} + {2'b00, tcpcs_pkg::PROTO_TCP}
              + {2'b00, scnt_next};
        fold1 = {1'b0, total[15:0]} + {15'd0, total[17:16]};
        fold2 = fold1[15:0] + {15'd0, fold1[16]};

        out_short_next = (hcnt_next < tcpcs_pkg::HDR_MIN_LEN)
                      || (scnt_next < tcpcs_pkg::SEG_MIN_LEN);
        out_csum_next  = (out_short_next || ovf_next) ? 16'h0000 : ~fold2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg   <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            hcnt_reg <= '0;
            scnt_reg <= '0;
            held_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (process)
        begin
            if (in_last_reg)
            begin
                sum_reg  <= '0;
                hcnt_reg <= '0;
                scnt_reg <= '0;
                held_reg <= '0;
                ovf_reg  <= 1'b0;
            end
            else
            begin
                sum_reg  <= sum_next;
                hcnt_reg <= hcnt_next;
                scnt_reg <= scnt_next;
                held_reg <= held_next;
                ovf_reg  <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (process && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && in_last_reg)
        begin
            out_csum_reg  <= out_csum_next;
            out_short_reg <= out_short_next;
            out_long_reg  <= ovf_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_csum_reg;
    assign m_axis_tuser  = {out_long_reg, out_short_reg};

endmodule

// ----- hw/rtl/tcpcs_checker.sv -----
module tcpcs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    logic in_last_beat;
    assign in_last_beat = s_axis_tvalid && s_axis_tready && s_axis_tlast;

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // flagged packets report a zero checksum
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[0] || m_axis_tuser[1])
        |-> m_axis_tdata == {tcpcs_pkg::CSUM_W{1'b0}})
        else $error("flagged result with nonzero checksum");

    // a fresh result follows an accepted tlast beat
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !$past(m_axis_tvalid) |-> $past(in_last_beat, 2))
        else $error("result beat without a preceding last byte");

    // the valid flop is cleared asynchronously by reset
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result valid during reset");

endmodule

bind tcp_checksum_ipv4_pseudo_header_top tcpcs_checker u_tcpcs_checker (.*);

// ----- tb/tcp_checksum_ipv4_pseudo_header_top_tb.sv -----
module tcp_checksum_ipv4_pseudo_header_top_tb;

    localparam int ADDR_FIRST  = 12;
    localparam int MIN_BYTES   = 20;
    localparam int SEG_LIMIT   = 65535;
    localparam int CSUM_FIELD  = 16;
    localparam logic [15:0] TCP_PROTO = 16'd6;

    typedef enum int {HEADER_FIRST, SEGMENT_FIRST, MIXED} byte_order_t;
    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

    typedef struct packed {
        logic [15:0] checksum;
        logic        too_short;
        logic        overlong;
    } csum_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tuser = tcpcs_pkg::OP_HEADER;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // predictor state
    logic [15:0] pkt_sum;
    int          hdr_bytes;
    int          seg_bytes;
    logic [7:0]  seg_high;
    logic        seg_overflow;

    csum_result_t expected_sums[$];
    int           bytes_taken;
    int           sums_predicted;
    int           mismatches;
    bit           calm;

    tcp_checksum_ipv4_pseudo_header_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [15:0] oc_sum(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] t;
        t = {16'd0, a} + {16'd0, b};
        return t[15:0] + t[31:16];
    endfunction

    function automatic void clear_packet();
        pkt_sum = 16'd0;
        hdr_bytes = 0;
        seg_bytes = 0;
        seg_high = 8'd0;
        seg_overflow = 1'b0;
    endfunction

    // returns 1 when the byte closes a packet and r holds its checksum
    function automatic bit fold_in_byte(input logic op, input logic [7:0] b,
                                        input logic lst, output csum_result_t r);
        logic short_pkt;
        r = '0;
        if (op == tcpcs_pkg::OP_HEADER)
        begin
            if (hdr_bytes < MIN_BYTES)
            begin
                if (hdr_bytes >= ADDR_FIRST)
                    pkt_sum = oc_sum(pkt_sum, hdr_bytes[0] ? {8'd0, b} : {b, 8'd0});
                hdr_bytes++;
            end
        end
        else if (seg_bytes >= SEG_LIMIT)
            seg_overflow = 1'b1;
        else
        begin
            if (!seg_bytes[0])
                seg_high = b;
            else if (seg_bytes - 1 != CSUM_FIELD)
                pkt_sum = oc_sum(pkt_sum, {seg_high, b});
            seg_bytes++;
        end
        if (!lst)
            return 1'b0;
        short_pkt = (hdr_bytes < MIN_BYTES) || (seg_bytes < MIN_BYTES);
        if (!short_pkt && !seg_overflow)
        begin
            // odd tail byte is padded with a zero low byte
            if (seg_bytes[0])
                pkt_sum = oc_sum(pkt_sum, {seg_high, 8'd0});
            pkt_sum = oc_sum(pkt_sum, TCP_PROTO);
            pkt_sum = oc_sum(pkt_sum, seg_bytes[15:0]);
            r.checksum = ~pkt_sum;
        end
        r.too_short = short_pkt;
        r.overlong = seg_overflow;
        clear_packet();
        return 1'b1;
    endfunction

    task automatic send_byte(input logic op, input logic [7:0] b, input logic lst);
        csum_result_t r;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= op;
        s_axis_tlast <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_taken++;
        if (fold_in_byte(op, b, lst, r))
        begin
            expected_sums.push_back(r);
            sums_predicted++;
        end
    endtask

    task automatic send_packet(input int hdr_len, input int seg_len, input byte_order_t order,
                               input fill_t fill, input bit close);
        int h;
        int s;
        int total;
        logic op;
        logic [7:0] b;
        h = 0;
        s = 0;
        total = hdr_len + seg_len;
        for (int k = 0; k < total; k++)
        begin
            case (order)
                HEADER_FIRST:
                    op = (h < hdr_len) ? tcpcs_pkg::OP_HEADER : tcpcs_pkg::OP_SEGMENT;
                SEGMENT_FIRST:
                    op = (s < seg_len) ? tcpcs_pkg::OP_SEGMENT : tcpcs_pkg::OP_HEADER;
                default:
                    if (h == hdr_len)
                        op = tcpcs_pkg::OP_SEGMENT;
                    else if (s == seg_len)
                        op = tcpcs_pkg::OP_HEADER;
                    else
                        op = $urandom_range(0, 1) ? tcpcs_pkg::OP_SEGMENT
                                                  : tcpcs_pkg::OP_HEADER;
            endcase
            if (op == tcpcs_pkg::OP_HEADER)
                h++;
            else
                s++;
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                default:   b = 8'($urandom_range(0, 255));
            endcase
            send_byte(op, b, close && (k == total - 1));
        end
    endtask

    // receiver side with random stall bursts
    always @(posedge clk)
    begin
        if (calm || $urandom_range(0, 5) != 0)
            m_axis_tready <= 1'b1;
        else
        begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        csum_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_sums.size() == 0)
            begin
                $error("result beat with nothing expected: checksum %h flags %b",
                       m_axis_tdata, m_axis_tuser);
                mismatches++;
            end
            else
            begin
                want = expected_sums.pop_front();
                if (m_axis_tdata !== want.checksum)
                begin
                    $error("checksum: expected %h, got %h", want.checksum, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tuser[0] !== want.too_short)
                begin
                    $error("too_short: expected %b, got %b", want.too_short, m_axis_tuser[0]);
                    mismatches++;
                end
                if (m_axis_tuser[1] !== want.overlong)
                begin
                    $error("overlong: expected %b, got %b", want.overlong, m_axis_tuser[1]);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_extremes();
        send_packet(20, 20, HEADER_FIRST, FILL_ZERO, 1'b1);
        send_packet(20, 20, HEADER_FIRST, FILL_ONES, 1'b1);
        send_packet(20, 21, HEADER_FIRST, FILL_ONES, 1'b1);
        send_packet(20, 20, HEADER_FIRST, FILL_RANDOM, 1'b1);
        send_packet(20, 33, HEADER_FIRST, FILL_RANDOM, 1'b1);
    endtask

    task automatic test_short_packets();
        send_packet(19, 20, HEADER_FIRST, FILL_RANDOM, 1'b1);
        send_packet(20, 19, HEADER_FIRST, FILL_RANDOM, 1'b1);
        send_packet(0, 25, HEADER_FIRST, FILL_RANDOM, 1'b1);
        send_packet(3, 0, HEADER_FIRST, FILL_RANDOM, 1'b1);
        send_packet(0, 1, HEADER_FIRST, FILL_ONES, 1'b1);
    endtask

    task automatic test_long_header();
        send_packet(27, 30, HEADER_FIRST, FILL_RANDOM, 1'b1);
        send_packet(31, 20, HEADER_FIRST, FILL_ONES, 1'b1);
    endtask

    task automatic test_kind_order();
        // last byte lands on a header byte here
        send_packet(20, 22, SEGMENT_FIRST, FILL_RANDOM, 1'b1);
        send_packet(20, 27, MIXED, FILL_RANDOM, 1'b1);
        send_packet(24, 20, MIXED, FILL_RANDOM, 1'b1);
    endtask

    task automatic test_split_packet();
        // first part has no tlast, so the sum carries into the second part
        send_packet(10, 10, HEADER_FIRST, FILL_RANDOM, 1'b0);
        send_packet(10, 13, HEADER_FIRST, FILL_RANDOM, 1'b1);
    endtask

    task automatic test_max_segment();
        calm = 1'b1;
        send_packet(20, SEG_LIMIT, HEADER_FIRST, FILL_RANDOM, 1'b1);
        calm = 1'b0;
    endtask

    task automatic test_overlong();
        calm = 1'b1;
        send_packet(20, SEG_LIMIT + 1, HEADER_FIRST, FILL_RANDOM, 1'b1);
        send_packet(4, SEG_LIMIT + 60, MIXED, FILL_RANDOM, 1'b1);
        calm = 1'b0;
    endtask

    task automatic send_random_packet();
        int pick;
        int seg_len;
        pick = $urandom_range(0, 19);
        seg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 300) : $urandom_range(20, 48);
        case (pick)
            14: send_packet($urandom_range(21, 30), seg_len, HEADER_FIRST, FILL_RANDOM, 1'b1);
            15: send_packet(20, seg_len, MIXED, FILL_RANDOM, 1'b1);
            16: send_packet($urandom_range(0, 19), seg_len, HEADER_FIRST, FILL_RANDOM, 1'b1);
            17: send_packet(20, $urandom_range(0, 19), HEADER_FIRST, FILL_RANDOM, 1'b1);
            18: send_packet(20, seg_len, SEGMENT_FIRST, FILL_RANDOM, 1'b1);
            19: send_packet($urandom_range(1, 40), $urandom_range(0, 40), MIXED, FILL_RANDOM,
                            $urandom_range(0, 3) != 0);
            default: send_packet(20, seg_len, HEADER_FIRST, FILL_RANDOM, 1'b1);
        endcase
    endtask

    task automatic test_random_traffic();
        int first_bytes;
        int first_sums;
        first_bytes = bytes_taken;
        first_sums = sums_predicted;
        while (bytes_taken - first_bytes < 1150 || sums_predicted - first_sums < 40)
            send_random_packet();
        // close any packet left open by a packet without tlast
        send_packet(20, 20, HEADER_FIRST, FILL_RANDOM, 1'b1);
    endtask

    task automatic test_back_to_back();
        calm = 1'b1;
        repeat (5)
            send_packet(20, $urandom_range(20, 40), HEADER_FIRST, FILL_RANDOM, 1'b1);
        s_axis_tvalid <= 1'b0;
    endtask

    initial
    begin
        int guard;
        clear_packet();
        bytes_taken = 0;
        sums_predicted = 0;
        mismatches = 0;
        calm = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_short_packets();
        test_long_header();
        test_kind_order();
        test_split_packet();
        test_max_segment();
        test_overlong();
        test_random_traffic();
        test_back_to_back();

        guard = 0;
        while (expected_sums.size() != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (expected_sums.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_sums.size());
            mismatches++;
        end

        if (mismatches == 0)
            $display("** tcp_checksum_ipv4_pseudo_header_top: PASSED **");
        else
            $display("** tcp_checksum_ipv4_pseudo_header_top: FAILED **");
        $finish;
    end

    initial
    begin
        #24_000_000;
        $display("** tcp_checksum_ipv4_pseudo_header_top: FAILED **");
        $finish;
    end

endmodule
